// File: hdl/mws_pkg.sv
package mws_pkg;

  localparam int KEY_MAX_DEF       = 8;
  localparam int POSITION_BITS_DEF = 16;

  localparam int SYM_W     = 8;
  localparam int LEN_W     = 4;
  localparam int BEST_W    = 17;
  localparam int OUT_LEN_W = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_SYMBOLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 1'b1;

  localparam logic [BEST_W-1:0]    BEST_NONE   = 17'h1FFFF;
  localparam logic [BEST_W-1:0]    BEST_SAT    = 17'h1FFFE;
  localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             end_of_message;
  } in_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] shortest_length;
    logic                 not_found;
  } out_t;

endpackage

// File: hdl/mws_cell.sv
module mws_cell import mws_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     clear,
  input  logic                     enable,
  input  logic [SYM_W-1:0]         key_sym,
  input  logic [SYM_W-1:0]         symbol,
  input  logic [POSITION_BITS-1:0] prev_start,
  input  logic                     prev_valid,
  output logic [POSITION_BITS-1:0] start_r,
  output logic                     valid_r,
  output logic                     load,
  output logic [POSITION_BITS-1:0] load_start
);

  assign load       = step && enable && (key_sym == symbol) && prev_valid;
  assign load_start = prev_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      valid_r <= 1'b0;
    end else if (clear) begin
      start_r <= '0;
      valid_r <= 1'b0;
    end else if (load) begin
      start_r <= prev_start;
      valid_r <= 1'b1;
    end
  end

endmodule

// File: hdl/min_window_subsequence.sv
// Minimum window subsequence finder.
// Input channel (in_valid / in_ready / in_data): one message symbol per word,
// with end_of_message set on the last symbol of a message. Each word is
// matched against the key by a row of key cells, one per key symbol,
// each but the first taking the start index held by its left neighbor.
// Output channel (out_valid / out_ready / out_data): one word per message,
// emitted for the end_of_message word: the shortest window length holding
// the key as a subsequence, or not_found with a length of 0.
// Throughput is one symbol per cycle; the result appears in the cycle after
// the end_of_message word is accepted, from a single output register.
// While that result waits for out_ready, in_ready stays low; otherwise the
// block takes a word every cycle.
// Configuration (cfg_we / cfg_index / cfg_data): index 0 writes the packed
// key symbols, key position 0 in the low byte; index 1 writes the key length
// (0 acts as 1, above KEY_MAX as KEY_MAX). Writes take effect at once.
// Reset (rst_n low, synchronous) clears the message state, empties the
// output register and restores an all-zero key of length 1.
module min_window_subsequence import mws_pkg::*; #(
  parameter int KEY_MAX       = KEY_MAX_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int WW = (POSITION_BITS + 1 > BEST_W) ? POSITION_BITS + 1 : BEST_W;

  logic [CFG_W-1:0]         key_symbols_r;
  logic [LEN_W-1:0]         key_length_r;
  logic [LEN_W-1:0]         used_len;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic [BEST_W-1:0]        best_r;
  logic [BEST_W-1:0]        best_nxt;
  logic                     out_valid_r;
  out_t                     out_data_r;
  out_t                     out_data_nxt;
  logic                     accept;
  logic                     clear;

  logic [POSITION_BITS-1:0] cell_start [KEY_MAX];
  logic [KEY_MAX-1:0]       cell_valid;
  logic [KEY_MAX-1:0]       cell_load;
  logic [POSITION_BITS-1:0] cell_load_start [KEY_MAX];

  logic                     last_load;
  logic [POSITION_BITS-1:0] last_start;
  logic [WW-1:0]            win;
  logic [BEST_W-1:0]        win_sat;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign clear     = accept && in_data.end_of_message;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (key_length_r == '0) begin
      used_len = LEN_W'(1);
    end else if (key_length_r > LEN_W'(KEY_MAX)) begin
      used_len = LEN_W'(KEY_MAX);
    end else begin
      used_len = key_length_r;
    end
  end

  for (genvar j = 0; j < KEY_MAX; j++) begin : g_cell
    logic [POSITION_BITS-1:0] prev_start;
    logic                     prev_valid;

    if (j == 0) begin : g_head
      assign prev_start = pos_r;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_start = cell_start[j-1];
      assign prev_valid = cell_valid[j-1];
    end

    mws_cell #(
      .POSITION_BITS (POSITION_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (accept),
      .clear      (clear),
      .enable     (LEN_W'(j) < used_len),
      .key_sym    (key_symbols_r[SYM_W*j +: SYM_W]),
      .symbol     (in_data.symbol),
      .prev_start (prev_start),
      .prev_valid (prev_valid),
      .start_r    (cell_start[j]),
      .valid_r    (cell_valid[j]),
      .load       (cell_load[j]),
      .load_start (cell_load_start[j])
    );
  end

  always_comb begin
    last_load  = 1'b0;
    last_start = '0;
    for (int j = 0; j < KEY_MAX; j++) begin
      if (LEN_W'(j) == used_len - LEN_W'(1)) begin
        last_load  = cell_load[j];
        last_start = cell_load_start[j];
      end
    end
  end

  always_comb begin
    win = WW'(pos_r) - WW'(last_start) + WW'(1);
    if (win > WW'(BEST_SAT)) begin
      win_sat = BEST_SAT;
    end else begin
      win_sat = win[BEST_W-1:0];
    end
    best_nxt = best_r;
    if (last_load && (win_sat < best_r)) begin
      best_nxt = win_sat;
    end
    pos_nxt = pos_r;
    if (pos_r != '1) begin
      pos_nxt = pos_r + POSITION_BITS'(1);
    end
    if (best_nxt == BEST_NONE) begin
      out_data_nxt.shortest_length = '0;
      out_data_nxt.not_found       = 1'b1;
    end else begin
      out_data_nxt.shortest_length = (best_nxt > BEST_W'(OUT_LEN_MAX)) ?
                                     OUT_LEN_MAX : best_nxt[OUT_LEN_W-1:0];
      out_data_nxt.not_found       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_symbols_r <= '0;
      key_length_r  <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_SYMBOLS: key_symbols_r <= cfg_data;
        REG_KEY_LENGTH:  key_length_r  <= cfg_data[LEN_W-1:0];
        default:         key_length_r  <= key_length_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      best_r      <= BEST_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (clear) begin
        pos_r  <= '0;
        best_r <= BEST_NONE;
      end else if (accept) begin
        pos_r  <= pos_nxt;
        best_r <= best_nxt;
      end
      if (clear) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: hdl/mws_checker.sv
module mws_checker import mws_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("output word present right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_word_from_eom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.end_of_message))
    else $error("output word without an end of message");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.not_found |-> out_data.shortest_length == '0)
    else $error("not_found word with nonzero length");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output word is stalled");

endmodule

bind min_window_subsequence mws_checker u_mws_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
